/* rtl/core/utf8_stream_decoder_defines.svh */
// Assertion macros used by the decoder checker.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define UTF8SD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define UTF8SD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define UTF8SD_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/utf8sd_pkg.sv */
// Shared types and constants of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package utf8sd_pkg;

    localparam int unsigned CodeW = 21;

    // byte classes
    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContTag   = 8'h80;
    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Tag  = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Tag  = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Tag  = 8'hF0;

    // code point limits
    localparam logic [CodeW-1:0] MinTwo    = 21'h000080;
    localparam logic [CodeW-1:0] MinThree  = 21'h000800;
    localparam logic [CodeW-1:0] MinFour   = 21'h010000;
    localparam logic [CodeW-1:0] SurLo     = 21'h00D800;
    localparam logic [CodeW-1:0] SurHi     = 21'h00DFFF;
    localparam logic [CodeW-1:0] MaxScalar = 21'h10FFFF;
    localparam logic [CodeW-1:0] RepReset  = 21'h00FFFD;

    typedef logic [CodeW-1:0] t_code;

    // One byte's worth of results: nrep replacements, then optionally one good code.
    typedef struct packed {
        logic [2:0] nrep;
        logic       has_good;
        t_code      good_code;
    } t_desc;

endpackage

/* rtl/core/utf8sd_front.sv */
// Front end: accepts bytes, tracks the pending sequence, emits result descriptors.
`timescale 1ns / 1ps

module utf8sd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_valid,
    output logic               o_byte_ready,
    input  logic [7:0]         i_byte,
    input  logic               i_final,
    input  logic               i_queue_full,
    output logic               o_push,
    output utf8sd_pkg::t_desc  o_desc
);

    logic [1:0]         r_seq_len;
    logic [1:0]         r_cont_seen;
    utf8sd_pkg::t_code  r_partial;
    logic [1:0]         n_seq_len;
    logic [1:0]         n_cont_seen;
    utf8sd_pkg::t_code  n_partial;

    logic               accept;
    logic               is_cont;
    logic               use_fresh;
    logic               bad;
    logic [2:0]         seen;
    logic [2:0]         seq3;
    utf8sd_pkg::t_code  cont_v;
    utf8sd_pkg::t_code  minv;
    utf8sd_pkg::t_desc  desc;

    assign o_byte_ready = !i_queue_full;
    assign accept       = i_byte_valid && !i_queue_full;
    assign is_cont      = (i_byte & utf8sd_pkg::ContMask) == utf8sd_pkg::ContTag;
    assign cont_v       = {r_partial[14:0], i_byte[5:0]};
    assign seen         = {1'b0, r_cont_seen} + 3'd1;
    assign seq3         = {1'b0, r_seq_len};

    always_comb begin
        case (r_seq_len)
            2'd1:    minv = utf8sd_pkg::MinTwo;
            2'd2:    minv = utf8sd_pkg::MinThree;
            default: minv = utf8sd_pkg::MinFour;
        endcase
    end

    assign bad = (cont_v < minv) ||
                 ((cont_v >= utf8sd_pkg::SurLo) && (cont_v <= utf8sd_pkg::SurHi)) ||
                 (cont_v > utf8sd_pkg::MaxScalar);

    always_comb begin
        n_seq_len   = r_seq_len;
        n_cont_seen = r_cont_seen;
        n_partial   = r_partial;
        desc        = '0;
        use_fresh   = 1'b0;

        if (r_seq_len == 2'd0) begin
            use_fresh = 1'b1;
        end else if (is_cont) begin
            if (seen >= seq3) begin
                if (bad) begin
                    desc.nrep = seq3 + 3'd1;
                end else begin
                    desc.has_good  = 1'b1;
                    desc.good_code = cont_v;
                end
                n_seq_len   = 2'd0;
                n_cont_seen = 2'd0;
                n_partial   = '0;
            end else if (i_final) begin
                // truncated at end of text
                desc.nrep   = seen + 3'd1;
                n_seq_len   = 2'd0;
                n_cont_seen = 2'd0;
                n_partial   = '0;
            end else begin
                n_cont_seen = seen[1:0];
                n_partial   = cont_v;
            end
        end else begin
            // missing continuation: flush the sequence, then take the byte afresh
            desc.nrep   = {1'b0, r_cont_seen} + 3'd1;
            n_seq_len   = 2'd0;
            n_cont_seen = 2'd0;
            n_partial   = '0;
            use_fresh   = 1'b1;
        end

        if (use_fresh) begin
            if (!i_byte[7]) begin
                desc.has_good  = 1'b1;
                desc.good_code = {13'd0, i_byte};
            end else if ((i_byte & utf8sd_pkg::Lead2Mask) == utf8sd_pkg::Lead2Tag ||
                         (i_byte & utf8sd_pkg::Lead3Mask) == utf8sd_pkg::Lead3Tag ||
                         (i_byte & utf8sd_pkg::Lead4Mask) == utf8sd_pkg::Lead4Tag) begin
                if (i_final) begin
                    desc.nrep = desc.nrep + 3'd1;
                end else if ((i_byte & utf8sd_pkg::Lead2Mask) == utf8sd_pkg::Lead2Tag) begin
                    n_seq_len = 2'd1;
                    n_partial = {16'd0, i_byte[4:0]};
                end else if ((i_byte & utf8sd_pkg::Lead3Mask) == utf8sd_pkg::Lead3Tag) begin
                    n_seq_len = 2'd2;
                    n_partial = {17'd0, i_byte[3:0]};
                end else begin
                    n_seq_len = 2'd3;
                    n_partial = {18'd0, i_byte[2:0]};
                end
            end else begin
                desc.nrep = desc.nrep + 3'd1;   // invalid lead
            end
        end
    end

    assign o_desc = desc;
    assign o_push = accept && ((desc.nrep != 3'd0) || desc.has_good);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len   <= 2'd0;
            r_cont_seen <= 2'd0;
            r_partial   <= '0;
        end else if (accept) begin
            r_seq_len   <= n_seq_len;
            r_cont_seen <= n_cont_seen;
            r_partial   <= n_partial;
        end
    end

endmodule

/* rtl/core/utf8sd_queue.sv */
// Descriptor queue between the front and back ends.
`timescale 1ns / 1ps

module utf8sd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  utf8sd_pkg::t_desc  i_desc,
    output logic               o_full,
    output logic               o_valid,
    output utf8sd_pkg::t_desc  o_desc,
    input  logic               i_pop
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    utf8sd_pkg::t_desc r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [CntW-1:0]   r_cnt;
    logic              pop;

    assign o_full  = r_cnt == FullCnt;
    assign o_valid = r_cnt != '0;
    assign o_desc  = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/core/utf8sd_back.sv */
// Back end: expands descriptors into the output register, one word per cycle when ready.
`timescale 1ns / 1ps

module utf8sd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  utf8sd_pkg::t_code  i_rep_code,
    input  logic               i_desc_valid,
    input  utf8sd_pkg::t_desc  i_desc,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output utf8sd_pkg::t_code  o_code,
    output logic               o_malformed,
    output logic               o_last
);

    logic [1:0]        r_idx;
    logic              r_valid;
    utf8sd_pkg::t_code r_code;
    logic              r_malformed;
    logic              r_last;

    logic [2:0]        total;
    logic              is_rep;
    logic              last;
    logic              load;

    assign total  = i_desc.nrep + {2'd0, i_desc.has_good};
    assign is_rep = {1'b0, r_idx} < i_desc.nrep;
    assign last   = ({1'b0, r_idx} + 3'd1) == total;
    assign load   = i_desc_valid && (!r_valid || i_ready);
    assign o_pop  = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code      <= is_rep ? i_rep_code : i_desc.good_code;
            r_malformed <= is_rep;
            r_last      <= last;
        end
    end

    assign o_valid     = r_valid;
    assign o_code      = r_code;
    assign o_malformed = r_malformed;
    assign o_last      = r_last;

endmodule

/* rtl/core/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder with per-byte replacement.
`timescale 1ns / 1ps

// UTF-8 stream decoder. Bytes enter on the slave stream, one word per byte, with
// tlast marking the final byte of the text (it flushes a pending sequence). Each
// decoded code point leaves on the master stream; a malformed byte yields the
// replacement code with tuser set, one word per bad byte (lead first, then each
// buffered continuation), and decoding resumes at the next byte. tlast on the
// output marks the last word caused by one input byte; bytes that only open or
// extend a sequence produce nothing. Throughput: one byte per cycle in while the
// queue has room, one word per cycle out while the output is ready. The front end
// classifies a byte in the cycle it is accepted; a byte that causes k words (k up
// to 4) holds the back end until its last word is loaded; the QUEUE_DEPTH-entry
// descriptor queue between them absorbs such bursts. Input stalls only when that
// queue is full, output stalls never block input until then. The replacement
// code register resets to U+FFFD and is written through the cfg channel, which is
// always ready; write it only while the decoder is idle.

module utf8_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,     // [7:0] byte_value
    input  logic        s_axis_tlast,     // final_byte
    // output code point stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,     // [20:0] code_value, [23:21] zero
    output logic        m_axis_tuser,     // [0] malformed
    output logic        m_axis_tlast,     // run_end
    // replacement code write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [20:0] i_cfg_data        // replacement_code
);

    utf8sd_pkg::t_code r_rep_code;

    logic              push;
    logic              queue_full;
    logic              queue_valid;
    logic              pop;
    utf8sd_pkg::t_desc push_desc;
    utf8sd_pkg::t_desc head_desc;
    utf8sd_pkg::t_code out_code;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_code <= utf8sd_pkg::RepReset;
        end else if (i_cfg_valid) begin
            r_rep_code <= i_cfg_data;
        end
    end

    utf8sd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_axis_tvalid),
        .o_byte_ready (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_final      (s_axis_tlast),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_desc       (push_desc)
    );

    utf8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_desc  (head_desc),
        .i_pop   (pop)
    );

    utf8sd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rep_code   (r_rep_code),
        .i_desc_valid (queue_valid),
        .i_desc       (head_desc),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_code       (out_code),
        .o_malformed  (m_axis_tuser),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_code};

endmodule

/* rtl/core/utf8sd_checker.sv */
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_defines.svh"

module utf8sd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [20:0] i_cfg_data
);

    utf8sd_pkg::t_code r_rep_code;
    utf8sd_pkg::t_code out_code;
    logic [25:0]       out_word;
    logic              out_rep;
    logic              out_good;
    logic              out_stall;
    logic              out_surrogate;
    logic              out_scalar;

    // shadow of the replacement code register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_code <= utf8sd_pkg::RepReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_rep_code <= i_cfg_data;
        end
    end

    assign out_code      = m_axis_tdata[20:0];
    assign out_word      = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign out_rep       = m_axis_tvalid && m_axis_tuser;
    assign out_good      = m_axis_tvalid && !m_axis_tuser;
    assign out_stall     = m_axis_tvalid && !m_axis_tready;
    assign out_surrogate = (out_code >= utf8sd_pkg::SurLo) && (out_code <= utf8sd_pkg::SurHi);
    assign out_scalar    = (m_axis_tdata[23:21] == 3'b000) &&
                           (out_code <= utf8sd_pkg::MaxScalar) && !out_surrogate;

    `UTF8SD_ASSERT_IMP(a_rep_code, out_rep, out_code == r_rep_code, "bad replacement code")

    `UTF8SD_ASSERT_IMP(a_scalar, out_good, out_scalar, "decoded word is not a scalar")

    `UTF8SD_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "word not held")

    `UTF8SD_ASSERT_RST(a_rst_idle, !i_rst_n, !m_axis_tvalid, "output valid right after reset")

endmodule

bind utf8_stream_decoder utf8sd_checker u_utf8sd_checker (.*);

/* test/tb.sv */
// Self-checking testbench for the UTF-8 stream decoder.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF    = 4;
    localparam int DRAIN_WAIT  = 8;          // margin for the back end to settle
    localparam int HOLD_CYCLES = 150;        // long output stall in the pressure phase
    localparam int TIMEOUT_NS  = 4_000_000;

    // one expected or observed code word
    typedef struct packed {
        utf8sd_pkg::t_code code;
        logic              bad;
        logic              last;
    } t_cp_word;

    // directed row: input byte, plus optional typed expectation (count words of code/bad)
    typedef struct packed {
        logic [7:0]        data;
        logic              fin;
        logic              typed;
        utf8sd_pkg::t_code code;
        logic              bad;
        logic [2:0]        count;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] byte_value
    logic        s_axis_tlast;     // final_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // [20:0] code_value, [23:21] zero
    logic        m_axis_tuser;     // [0] malformed
    logic        m_axis_tlast;     // run_end
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [20:0] i_cfg_data;       // replacement_code

    utf8_stream_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // decoder shadow state
    utf8sd_pkg::t_code rep_code;
    logic [1:0]        seq_len;
    logic [1:0]        cont_cnt;
    utf8sd_pkg::t_code acc;

    t_cp_word   byte_codes[$];     // words caused by the byte just accepted
    t_cp_word   pending_codes[$];  // words still owed by the decoder
    logic [7:0] char_bytes[$];     // encoded bytes of one random character

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    int err_cnt;
    int bytes_in;
    int good_out;
    int rep_out;
    int in_stalls;
    int cfg_writes;

    t_stim_row dir_rows [0:24] = '{
        '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0, 3'd1},   // lowest ASCII
        '{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0, 3'd1},   // highest ASCII
        '{8'h80, 1'b0, 1'b1, 21'h00FFFD, 1'b1, 3'd1},   // stray continuation
        '{8'hFF, 1'b0, 1'b1, 21'h00FFFD, 1'b1, 3'd1},   // invalid lead
        '{8'hC2, 1'b1, 1'b1, 21'h00FFFD, 1'b1, 3'd1},   // lead on the final byte
        '{8'hC2, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'h80, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},   // U+0080
        '{8'hDF, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'hBF, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},   // U+07FF
        '{8'hC0, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'h80, 1'b0, 1'b1, 21'h00FFFD, 1'b1, 3'd2},   // overlong
        '{8'hED, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'hA0, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'h80, 1'b0, 1'b1, 21'h00FFFD, 1'b1, 3'd3},   // surrogate
        '{8'hF4, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'h90, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'h80, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'h80, 1'b0, 1'b1, 21'h00FFFD, 1'b1, 3'd4},   // above U+10FFFF
        '{8'hF0, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'h90, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'h41, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},   // missing continuation
        '{8'hE2, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'h82, 1'b1, 1'b0, 21'h0,      1'b0, 3'd0},   // truncated on a continuation
        '{8'hE2, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
        '{8'h41, 1'b1, 1'b0, 21'h0,      1'b0, 3'd0}    // truncated on a non-continuation
    };

    // ---------------- prediction ----------------

    function void emit(input utf8sd_pkg::t_code c, input logic bad);
        byte_codes.insert(byte_codes.size(), t_cp_word'{c, bad, 1'b0});
    endfunction

    function void emit_reps(input int n);
        for (int i = 0; i < n; i++) emit(rep_code, 1'b1);
    endfunction

    function void clear_char();
        seq_len  = 2'd0;
        cont_cnt = 2'd0;
        acc      = '0;
    endfunction

    // byte seen with no sequence open
    function void start_char(input logic [7:0] b, input logic fin);
        logic [1:0]        n;
        utf8sd_pkg::t_code v;
        if (!b[7]) begin
            emit(utf8sd_pkg::t_code'(b), 1'b0);
            return;
        end
        if ((b & utf8sd_pkg::Lead2Mask) == utf8sd_pkg::Lead2Tag) begin
            n = 2'd1;
            v = utf8sd_pkg::t_code'(b[4:0]);
        end else if ((b & utf8sd_pkg::Lead3Mask) == utf8sd_pkg::Lead3Tag) begin
            n = 2'd2;
            v = utf8sd_pkg::t_code'(b[3:0]);
        end else if ((b & utf8sd_pkg::Lead4Mask) == utf8sd_pkg::Lead4Tag) begin
            n = 2'd3;
            v = utf8sd_pkg::t_code'(b[2:0]);
        end else begin
            emit_reps(1);
            return;
        end
        if (fin) begin
            emit_reps(1);
            return;
        end
        seq_len  = n;
        cont_cnt = 2'd0;
        acc      = v;
    endfunction

    function void decode_byte(input logic [7:0] b, input logic fin);
        utf8sd_pkg::t_code nv;
        utf8sd_pkg::t_code floor_val;
        int                seen;
        byte_codes.delete();
        if (seq_len == 2'd0) begin
            start_char(b, fin);
        end else if ((b & utf8sd_pkg::ContMask) == utf8sd_pkg::ContTag) begin
            nv   = {acc[14:0], b[5:0]};
            seen = cont_cnt + 1;
            if (seen >= seq_len) begin
                floor_val = (seq_len == 2'd1) ? utf8sd_pkg::MinTwo :
                            (seq_len == 2'd2) ? utf8sd_pkg::MinThree : utf8sd_pkg::MinFour;
                if (nv < floor_val ||
                    (nv >= utf8sd_pkg::SurLo && nv <= utf8sd_pkg::SurHi) ||
                    nv > utf8sd_pkg::MaxScalar)
                    emit_reps(seq_len + 1);
                else
                    emit(nv, 1'b0);
                clear_char();
            end else if (fin) begin
                emit_reps(seen + 1);
                clear_char();
            end else begin
                cont_cnt = seen[1:0];
                acc      = nv;
            end
        end else begin
            // broken sequence: flush it, then take the byte as new
            emit_reps(cont_cnt + 1);
            clear_char();
            start_char(b, fin);
        end
        if (byte_codes.size() > 0) byte_codes[$].last = 1'b1;
    endfunction

    // ---------------- checking ----------------

    task automatic report_err(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin : out_mon
        t_cp_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (m_axis_tuser) rep_out++; else good_out++;
            if (pending_codes.size() == 0) begin
                report_err($sformatf("unexpected word code=%h", m_axis_tdata[20:0]));
            end else begin
                want = pending_codes.pop_front();
                if (m_axis_tdata[20:0] !== want.code)
                    report_err($sformatf("code %h, want %h", m_axis_tdata[20:0], want.code));
                if (m_axis_tuser !== want.bad)
                    report_err($sformatf("malformed %b, want %b (code %h)",
                                         m_axis_tuser, want.bad, want.code));
                if (m_axis_tlast !== want.last)
                    report_err($sformatf("run_end %b, want %b (code %h)",
                                         m_axis_tlast, want.last, want.code));
            end
        end
    end

    // ---------------- drivers ----------------

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("%0t timeout, %0d words still owed", $realtime, pending_codes.size());
        $display("tb: errors");
        $finish;
    end

    // output side: random backpressure, or a long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin,
                             input logic typed = 1'b0, input utf8sd_pkg::t_code code = '0,
                             input logic bad = 1'b0, input int count = 0);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            in_stalls++;
            @(posedge i_clk);
        end
        bytes_in++;
        decode_byte(b, fin);
        if (typed) begin
            byte_codes.delete();
            for (int i = 0; i < count; i++)
                byte_codes.insert(byte_codes.size(), t_cp_word'{code, bad, (i == count - 1)});
        end
        foreach (byte_codes[i]) pending_codes.insert(pending_codes.size(), byte_codes[i]);
    endtask

    // drop valid, let every owed word out, then give the back end time to settle
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_codes.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_rep(input utf8sd_pkg::t_code v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        rep_code = v;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------- stimulus ----------------

    function void add_char_byte(input logic [7:0] b);
        char_bytes.insert(char_bytes.size(), b);
    endfunction

    // encode c in n bytes whether or not n is the shortest form
    function void encode_char(input utf8sd_pkg::t_code c, input int n);
        char_bytes.delete();
        case (n)
            1: add_char_byte({1'b0, c[6:0]});
            2: begin
                add_char_byte({3'b110, c[10:6]});
                add_char_byte({2'b10, c[5:0]});
            end
            3: begin
                add_char_byte({4'b1110, c[15:12]});
                add_char_byte({2'b10, c[11:6]});
                add_char_byte({2'b10, c[5:0]});
            end
            default: begin
                add_char_byte({5'b11110, c[20:18]});
                add_char_byte({2'b10, c[17:12]});
                add_char_byte({2'b10, c[11:6]});
                add_char_byte({2'b10, c[5:0]});
            end
        endcase
    endfunction

    function automatic utf8sd_pkg::t_code legal_code(input int n);
        case (n)
            2:       return utf8sd_pkg::t_code'($urandom_range(32'h7FF, 32'h80));
            3:       return utf8sd_pkg::t_code'($urandom_range(32'hFFFF, 32'hE000));
            default: return utf8sd_pkg::t_code'($urandom_range(32'h10FFFF, 32'h10000));
        endcase
    endfunction

    // mostly well-formed characters; the rest overlong, surrogate, too large,
    // cut short, or plain noise. Any byte may carry the final flag.
    task automatic send_random_char();
        int                pick;
        int                n;
        int                cut;
        utf8sd_pkg::t_code c;
        pick = $urandom_range(99);
        n    = 1;
        cut  = 0;
        c    = '0;
        if (pick < 30) begin
            c = utf8sd_pkg::t_code'($urandom_range(127));
        end else if (pick < 45) begin
            n = 2;
            c = legal_code(2);
        end else if (pick < 60) begin
            n = 3;
            c = utf8sd_pkg::t_code'($urandom_range(32'hFFFF, 32'h800));
        end else if (pick < 72) begin
            n = 4;
            c = legal_code(4);
        end else if (pick < 78) begin
            n = $urandom_range(4, 2);
            c = utf8sd_pkg::t_code'($urandom_range(n == 2 ? 32'h7F :
                                                   n == 3 ? 32'h7FF : 32'hFFFF));
        end else if (pick < 82) begin
            n = 3;
            c = utf8sd_pkg::t_code'($urandom_range(32'hDFFF, 32'hD800));
        end else if (pick < 86) begin
            n = 4;
            c = utf8sd_pkg::t_code'($urandom_range(32'h1FFFFF, 32'h110000));
        end else if (pick < 93) begin
            n   = $urandom_range(4, 2);
            c   = legal_code(n);
            cut = $urandom_range(n - 1, 1);
        end else begin
            repeat ($urandom_range(3, 1))
                send_byte(8'($urandom_range(255)), ($urandom_range(31) == 0));
            return;
        end
        encode_char(c, n);
        for (int i = 0; i < n - cut; i++)
            send_byte(char_bytes[i], ($urandom_range(31) == 0));
    endtask

    task automatic run_text(input int count);
        int stop_at;
        stop_at = bytes_in + count;
        while (bytes_in < stop_at) send_random_char();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        hold_req      = 1'b0;
        tx_idle_pct   = 38;
        rx_idle_pct   = 74;
        err_cnt       = 0;
        bytes_in      = 0;
        good_out      = 0;
        rep_out       = 0;
        in_stalls     = 0;
        cfg_writes    = 0;
        rep_code      = utf8sd_pkg::RepReset;
        clear_char();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, reset replacement code
        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].typed,
                      dir_rows[i].code, dir_rows[i].bad, dir_rows[i].count);

        write_rep('0);
        run_text(150);

        tx_idle_pct = 74;
        rx_idle_pct = 38;
        write_rep('1);
        run_text(150);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_rep(utf8sd_pkg::t_code'($urandom_range(32'h10FFFF)));
        run_text(110);

        // output held off while bytes keep coming: the descriptor queue fills
        // and the input must stall
        write_rep(utf8sd_pkg::RepReset);
        hold_req = 1'b1;
        repeat (10) send_byte(8'($urandom_range(8'hFF, 8'h80)), 1'b0);
        run_text(15);

        wait_idle();

        $display("summary: %0d bytes in, %0d scalars and %0d replacements out",
                 bytes_in, good_out, rep_out);
        $display("summary: %0d replacement code writes, %0d input stall cycles",
                 cfg_writes, in_stalls);
        if (err_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
